// File: rtl/detection_row_decoder_top_macros.svh
// Assertion macros for the detection row decoder, clocked on clk, disabled in reset.
`ifndef DETECTION_ROW_DECODER_TOP_MACROS_SVH
`define DETECTION_ROW_DECODER_TOP_MACROS_SVH

// Condition must hold at every clock edge outside reset.
`define DRD_ASSERT(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// When pre holds, post must hold in the next cycle.
`define DRD_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

// File: rtl/drd_pkg.sv
// Shared types, register codes and constants of the detection row decoder.
package drd_pkg;

    localparam int unsigned MAX_CLASSES_DEF = 1024;
    localparam int unsigned HEAD_DEPTH      = 7;
    localparam logic [10:0] IDX_MAX         = 11'd2047;
    localparam int unsigned MID_DEPTH       = 2;
    localparam int unsigned OUT_DEPTH       = 4;
    localparam int unsigned OUT_LVL_W       = $clog2(OUT_DEPTH + 1);

    localparam logic [2:0] MODE_RCNN      = 3'd0;
    localparam logic [2:0] MODE_SSD       = 3'd1;
    localparam logic [2:0] MODE_YOLO_NORM = 3'd2;
    localparam logic [2:0] MODE_YOLO_PIX  = 3'd3;
    localparam logic [2:0] MODE_YOLO10    = 3'd4;
    localparam logic [2:0] MODE_YOLO10_PP = 3'd5;

    localparam logic [2:0] REG_MODE       = 3'd0;
    localparam logic [2:0] REG_CONF_THR   = 3'd1;
    localparam logic [2:0] REG_BOX_THR    = 3'd2;
    localparam logic [2:0] REG_CLASS_OFF  = 3'd3;
    localparam logic [2:0] REG_MAX_BOXES  = 3'd4;
    localparam logic [2:0] REG_BLOB_W     = 3'd5;
    localparam logic [2:0] REG_BLOB_H     = 3'd6;

    typedef struct packed {
        logic [2:0]         mode;
        logic [16:0]        conf_thr;
        logic [16:0]        box_thr;
        logic signed [7:0]  class_off;
        logic [9:0]         max_boxes;
        logic [12:0]        blob_w;
        logic [12:0]        blob_h;
    } cfg_t;

    // One accepted row, already judged to emit, waiting for geometry.
    typedef struct packed {
        logic [2:0]         mode;
        logic signed [31:0] a0;
        logic signed [31:0] a1;
        logic signed [31:0] a2;
        logic signed [31:0] a3;
        logic signed [31:0] cls;
        logic signed [31:0] conf;
    } row_rec_t;

    typedef struct packed {
        logic signed [15:0] left;
        logic signed [15:0] top;
        logic signed [15:0] width;
        logic signed [15:0] height;
        logic signed [11:0] class_id;
        logic signed [31:0] confidence;
    } box_t;

endpackage

// File: rtl/drd_fifo.sv
// Small register queue used between front and back and in front of the result ports.
module drd_fifo #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 2
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         push,
    input  logic [WIDTH-1:0]             din,
    output logic                         full,
    input  logic                         pop,
    output logic [WIDTH-1:0]             dout,
    output logic                         empty,
    output logic [$clog2(DEPTH+1)-1:0]   level
);
    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned LW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [LW-1:0]    level_reg, level_next;
    logic             do_push, do_pop;

    assign full    = (level_reg == LW'(DEPTH));
    assign empty   = (level_reg == '0);
    assign level   = level_reg;
    assign dout    = mem_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        level_next  = level_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            level_next = level_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            level_next = level_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= din;
        end
    end

endmodule

// File: rtl/drd_front.sv
// Front end: row parsing, running first maximum, thresholds and frame box limit.
module drd_front #(
    parameter int unsigned MAX_CLASSES = drd_pkg::MAX_CLASSES_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  drd_pkg::cfg_t       cfg,
    input  logic                accept,
    input  logic signed [31:0]  value,
    input  logic                row_end,
    input  logic                frame_start,
    output logic                rec_push,
    output drd_pkg::row_rec_t   rec
);
    localparam int unsigned CLS_W = (MAX_CLASSES > 1) ? $clog2(MAX_CLASSES) : 1;

    logic [10:0]        field_index_reg, field_index_next;
    logic signed [31:0] head_reg [drd_pkg::HEAD_DEPTH];
    logic signed [31:0] best_score_reg, best_score_next;
    logic [CLS_W-1:0]   best_class_reg, best_class_next;
    logic [9:0]         box_count_reg, box_count_next;

    logic [10:0]        idx, start, c;
    logic [9:0]         bc;
    logic signed [31:0] hv [drd_pkg::HEAD_DEPTH];
    logic               is_y23, is_y, in_cls, upd, pass, emit;
    logic signed [31:0] nb;
    logic [CLS_W-1:0]   nc;
    logic signed [32:0] thr_c, thr_b;

    always_comb
    begin
        idx    = frame_start ? '0 : field_index_reg;
        bc     = frame_start ? '0 : box_count_reg;
        for (int i = 0; i < drd_pkg::HEAD_DEPTH; i++)
        begin
            hv[i] = (idx == 11'(i)) ? value : head_reg[i];
        end
        is_y23 = (cfg.mode == drd_pkg::MODE_YOLO_NORM) || (cfg.mode == drd_pkg::MODE_YOLO_PIX);
        is_y   = is_y23 || (cfg.mode == drd_pkg::MODE_YOLO10);
        start  = is_y23 ? 11'd5 : 11'd4;
        in_cls = is_y && (idx >= start);
        c      = idx - start;
        upd    = in_cls && (32'(c) < MAX_CLASSES) && ((c == '0) || (value > best_score_reg));
        nb     = upd ? value : best_score_reg;
        nc     = upd ? CLS_W'(c) : best_class_reg;
        thr_c  = $signed({16'd0, cfg.conf_thr});
        thr_b  = $signed({16'd0, cfg.box_thr});

        pass = 1'b0;
        rec  = '0;
        rec.mode = cfg.mode;
        case (cfg.mode)
            drd_pkg::MODE_RCNN, drd_pkg::MODE_SSD:
            begin
                pass     = 33'(hv[2]) > thr_c;
                rec.a0   = hv[3];
                rec.a1   = hv[4];
                rec.a2   = hv[5];
                rec.a3   = hv[6];
                rec.cls  = hv[1];
                rec.conf = hv[2];
            end
            drd_pkg::MODE_YOLO10_PP:
            begin
                pass     = 33'(hv[4]) > thr_c;
                rec.a0   = hv[0];
                rec.a1   = hv[1];
                rec.a2   = hv[2];
                rec.a3   = hv[3];
                rec.cls  = hv[5];
                rec.conf = hv[4];
            end
            drd_pkg::MODE_YOLO_NORM, drd_pkg::MODE_YOLO_PIX, drd_pkg::MODE_YOLO10:
            begin
                pass     = in_cls && (33'(nb) >= thr_c) && (!is_y23 || (33'(hv[4]) >= thr_b));
                rec.a0   = hv[0];
                rec.a1   = hv[1];
                rec.a2   = hv[2];
                rec.a3   = hv[3];
                rec.cls  = $signed(32'(nc));
                rec.conf = nb;
            end
            default:
            begin
                pass = 1'b0;
            end
        endcase

        emit     = row_end && pass && (bc < cfg.max_boxes);
        rec_push = accept && emit;

        if (row_end)
        begin
            field_index_next = '0;
            best_score_next  = '0;
            best_class_next  = '0;
        end
        else
        begin
            field_index_next = (idx < drd_pkg::IDX_MAX) ? idx + 1'b1 : idx;
            best_score_next  = nb;
            best_class_next  = nc;
        end
        box_count_next = bc + 10'(emit);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            field_index_reg <= '0;
            best_score_reg  <= '0;
            best_class_reg  <= '0;
            box_count_reg   <= '0;
        end
        else if (accept)
        begin
            field_index_reg <= field_index_next;
            best_score_reg  <= best_score_next;
            best_class_reg  <= best_class_next;
            box_count_reg   <= box_count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && (idx < 11'(drd_pkg::HEAD_DEPTH)))
        begin
            head_reg[idx[2:0]] <= value;
        end
    end

endmodule

// File: rtl/drd_back.sv
// Back end: scale by blob size, truncate, build the box and saturate.
module drd_back (
    input  logic                           clk,
    input  logic                           rst_n,
    input  drd_pkg::cfg_t                  cfg,
    input  drd_pkg::row_rec_t              rec,
    input  logic                           rec_empty,
    output logic                           rec_pop,
    input  logic [drd_pkg::OUT_LVL_W-1:0]  out_level,
    output logic                           out_push,
    output drd_pkg::box_t                  box
);
    logic               s1_valid_reg;
    logic [2:0]         s1_mode_reg;
    logic signed [46:0] s1_q0_reg, s1_q1_reg, s1_q2_reg, s1_q3_reg;
    logic signed [31:0] s1_cls_reg, s1_conf_reg;

    logic signed [46:0] q0, q1, q2, q3;
    logic signed [14:0] sxs, sys;
    logic               scale;
    logic signed [30:0] t0, t1, t2, t3;
    logic signed [30:0] tc;
    logic signed [32:0] gl, gt, gw, gh;
    logic signed [16:0] ct;
    logic signed [18:0] cs;

    function automatic logic signed [30:0] q_trunc(input logic signed [46:0] q);
        logic [46:0] mag;
        mag = q[46] ? 47'(-q) : q;
        return q[46] ? -$signed({1'b0, mag[45:16]}) : $signed({1'b0, mag[45:16]});
    endfunction

    function automatic logic signed [15:0] sat16(input logic signed [32:0] v);
        if (v > 33'sd32767)
        begin
            return 16'sh7FFF;
        end
        else if (v < -33'sd32768)
        begin
            return -16'sh8000;
        end
        return v[15:0];
    endfunction

    // Reserve room in the output queue for every row in flight.
    assign rec_pop = !rec_empty &&
                     ((32'(out_level) + 32'(s1_valid_reg)) < 32'(drd_pkg::OUT_DEPTH));

    always_comb
    begin
        scale = (rec.mode == drd_pkg::MODE_SSD) || (rec.mode == drd_pkg::MODE_YOLO_NORM);
        sxs   = scale ? $signed({2'b00, cfg.blob_w}) : 15'sd1;
        sys   = scale ? $signed({2'b00, cfg.blob_h}) : 15'sd1;
        q0    = rec.a0 * sxs;
        q1    = rec.a1 * sys;
        if (rec.mode == drd_pkg::MODE_YOLO10)
        begin
            q2 = 47'(rec.a2) - 47'(rec.a0) + 47'sd65536;
            q3 = 47'(rec.a3) - 47'(rec.a1) + 47'sd65536;
        end
        else
        begin
            q2 = rec.a2 * sxs;
            q3 = rec.a3 * sys;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= rec_pop;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rec_pop)
        begin
            s1_mode_reg <= rec.mode;
            s1_q0_reg   <= q0;
            s1_q1_reg   <= q1;
            s1_q2_reg   <= q2;
            s1_q3_reg   <= q3;
            s1_cls_reg  <= rec.cls;
            s1_conf_reg <= rec.conf;
        end
    end

    always_comb
    begin
        t0 = q_trunc(s1_q0_reg);
        t1 = q_trunc(s1_q1_reg);
        t2 = q_trunc(s1_q2_reg);
        t3 = q_trunc(s1_q3_reg);
        tc = q_trunc(47'(s1_cls_reg));
        ct = tc[16:0];
        cs = 19'(ct) + 19'(cfg.class_off);
        gl = 33'(t0);
        gt = 33'(t1);
        gw = 33'(t2);
        gh = 33'(t3);
        box.class_id = s1_cls_reg[11:0];
        case (s1_mode_reg)
            drd_pkg::MODE_RCNN, drd_pkg::MODE_SSD, drd_pkg::MODE_YOLO10_PP:
            begin
                gw = 33'(t2) - 33'(t0) + 33'sd1;
                gh = 33'(t3) - 33'(t1) + 33'sd1;
                if (cs > 19'sd2047)
                begin
                    box.class_id = 12'sh7FF;
                end
                else if (cs < -19'sd2048)
                begin
                    box.class_id = -12'sh800;
                end
                else
                begin
                    box.class_id = cs[11:0];
                end
            end
            drd_pkg::MODE_YOLO_NORM, drd_pkg::MODE_YOLO_PIX:
            begin
                gl = 33'(t0) - 33'(t2 / 2);
                gt = 33'(t1) - 33'(t3 / 2);
            end
            default:
            begin
                gl = 33'(t0);
            end
        endcase
        box.left       = sat16(gl);
        box.top        = sat16(gt);
        box.width      = sat16(gw);
        box.height     = sat16(gh);
        box.confidence = s1_conf_reg;
    end

    assign out_push = s1_valid_reg;

endmodule

// File: rtl/detection_row_decoder_top.sv
// Top level of the detection row decoder: config registers, front, queues and back.
//
//  channel  | handshake            | payload
//  ---------+----------------------+--------------------------------------------------
//  input    | push / full          | value, row_end, frame_start
//  results  | empty / pop          | box_left, box_top, box_width, box_height,
//           |                      | class_id, confidence
//  config   | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// One item is taken every cycle while full is low; the front parses and judges a row in
// the cycle its last item arrives. The row is then registered in the row queue, then, after
// the blob-size multiply, in the back end's stage register, and last in the result queue,
// at whose head the box waits on the result ports. Reset clears all control state and loads
// register defaults; the row head fields are undefined until written. A stalled result
// side fills the result queue, then the row queue, and only then raises full; cfg_ready
// is always high.
`include "detection_row_decoder_top_macros.svh"

module detection_row_decoder_top #(
    parameter int unsigned MAX_CLASSES = drd_pkg::MAX_CLASSES_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  logic signed [31:0]  value,
    input  logic                row_end,
    input  logic                frame_start,
    output logic                empty,
    input  logic                pop,
    output logic signed [15:0]  box_left,
    output logic signed [15:0]  box_top,
    output logic signed [15:0]  box_width,
    output logic signed [15:0]  box_height,
    output logic signed [11:0]  class_id,
    output logic signed [31:0]  confidence,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [2:0]          cfg_index,
    input  logic [31:0]         cfg_data
);
    drd_pkg::cfg_t      cfg_reg;
    drd_pkg::row_rec_t  rec_in, rec_out;
    drd_pkg::box_t      box_in, box_out;
    logic               accept, rec_push, rec_pop, rec_empty;
    logic               out_push, out_full;
    logic [$clog2(drd_pkg::MID_DEPTH+1)-1:0] mid_level;
    logic [drd_pkg::OUT_LVL_W-1:0]           out_level;

    assign cfg_ready = 1'b1;
    assign accept    = push && !full;

    // Hold register values; write the addressed one on a config handshake.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mode      <= drd_pkg::MODE_SSD;
            cfg_reg.conf_thr  <= 17'd32768;
            cfg_reg.box_thr   <= 17'd16384;
            cfg_reg.class_off <= '0;
            cfg_reg.max_boxes <= 10'd500;
            cfg_reg.blob_w    <= 13'd416;
            cfg_reg.blob_h    <= 13'd416;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                drd_pkg::REG_MODE:      cfg_reg.mode      <= cfg_data[2:0];
                drd_pkg::REG_CONF_THR:  cfg_reg.conf_thr  <= cfg_data[16:0];
                drd_pkg::REG_BOX_THR:   cfg_reg.box_thr   <= cfg_data[16:0];
                drd_pkg::REG_CLASS_OFF: cfg_reg.class_off <= $signed(cfg_data[7:0]);
                drd_pkg::REG_MAX_BOXES: cfg_reg.max_boxes <= cfg_data[9:0];
                drd_pkg::REG_BLOB_W:    cfg_reg.blob_w    <= cfg_data[12:0];
                drd_pkg::REG_BLOB_H:    cfg_reg.blob_h    <= cfg_data[12:0];
                default:
                begin
                    // drop writes beyond the register list
                end
            endcase
        end
    end

    drd_front #(
        .MAX_CLASSES(MAX_CLASSES)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .accept     (accept),
        .value      (value),
        .row_end    (row_end),
        .frame_start(frame_start),
        .rec_push   (rec_push),
        .rec        (rec_in)
    );

    // Row queue: full here backs up to the input side.
    drd_fifo #(
        .WIDTH($bits(drd_pkg::row_rec_t)),
        .DEPTH(drd_pkg::MID_DEPTH)
    ) u_mid_q (
        .clk  (clk),
        .rst_n(rst_n),
        .push (rec_push),
        .din  (rec_in),
        .full (full),
        .pop  (rec_pop),
        .dout (rec_out),
        .empty(rec_empty),
        .level(mid_level)
    );

    drd_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .rec      (rec_out),
        .rec_empty(rec_empty),
        .rec_pop  (rec_pop),
        .out_level(out_level),
        .out_push (out_push),
        .box      (box_in)
    );

    // Result queue: its head drives the result ports.
    drd_fifo #(
        .WIDTH($bits(drd_pkg::box_t)),
        .DEPTH(drd_pkg::OUT_DEPTH)
    ) u_out_q (
        .clk  (clk),
        .rst_n(rst_n),
        .push (out_push),
        .din  (box_in),
        .full (out_full),
        .pop  (pop),
        .dout (box_out),
        .empty(empty),
        .level(out_level)
    );

    assign box_left   = box_out.left;
    assign box_top    = box_out.top;
    assign box_width  = box_out.width;
    assign box_height = box_out.height;
    assign class_id   = box_out.class_id;
    assign confidence = box_out.confidence;

    `DRD_ASSERT(a_out_room, !(out_push && out_full), "result queue overflow")
    `DRD_ASSERT(a_mid_room, !(rec_push && full && !rec_pop), "row queue overflow")
    `DRD_ASSERT(a_pop_nonempty, !(rec_pop && (mid_level == '0)), "row popped from empty queue")
    `DRD_ASSERT_NEXT(a_pop_to_push, rec_pop, out_push, "row lost in back pipeline")

endmodule

// File: tb/sv/tb.sv
// Self-checking testbench for the detection row decoder top level.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CLASS_LIMIT = 1024;
    localparam int unsigned DRAIN_CYCLES = 12;
    localparam int unsigned MAX_SHOWN = 10;

    // One line of the directed table: a register write or an input item.
    typedef struct {
        bit                 is_cfg;
        logic [2:0]         reg_idx;
        logic [31:0]        reg_data;
        logic signed [31:0] v;
        bit                 last;
        bit                 fs;
        bit                 typed;
        drd_pkg::box_t      box;
    } drow_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               push = 1'b0;
    logic               full;
    logic signed [31:0] value = '0;
    logic               row_end = 1'b0;
    logic               frame_start = 1'b0;
    logic               empty;
    logic               pop = 1'b0;
    logic signed [15:0] box_left, box_top, box_width, box_height;
    logic signed [11:0] class_id;
    logic signed [31:0] confidence;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [2:0]         cfg_index = '0;
    logic [31:0]        cfg_data = '0;

    // Predictor copy of the registers and row state.
    drd_pkg::cfg_t      regs;
    logic [10:0]        pos;
    logic signed [31:0] head [drd_pkg::HEAD_DEPTH];
    logic signed [31:0] top_score;
    logic [9:0]         top_class;
    logic [9:0]         boxes_in_frame;

    drd_pkg::box_t pending_boxes [$];
    drow_t script [$];
    int    mismatches = 0;
    int    items_sent = 0;
    int    boxes_seen = 0;
    int    send_idle_pct = 32;
    int    recv_idle_pct = 48;
    int    hold_cycles = 0;

    detection_row_decoder_top uut (.*);

    always #5 clk = ~clk;

    // Receiver: check the oldest pending box at each accepted pop, then pick the next pop.
    always @(posedge clk) begin
        drd_pkg::box_t got;
        drd_pkg::box_t want;
        if (rst_n && pop && !empty) begin
            got = '{box_left, box_top, box_width, box_height, class_id, confidence};
            boxes_seen++;
            if (pending_boxes.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_SHOWN)
                    $display("unexpected box %p", got);
            end else begin
                want = pending_boxes.pop_front();
                if (got.left !== want.left || got.top !== want.top ||
                    got.width !== want.width || got.height !== want.height ||
                    got.class_id !== want.class_id || got.confidence !== want.confidence)
                begin
                    mismatches++;
                    if (mismatches <= MAX_SHOWN)
                        $display("box mismatch: expected %p got %p", want, got);
                end
            end
        end
        pop <= (hold_cycles == 0) && ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // Long receiver hold-off, counted down on its own.
    always @(posedge clk) begin
        if (hold_cycles > 0)
            hold_cycles <= hold_cycles - 1;
    end

    function automatic longint fx_trunc(longint q);
        return q >= 0 ? (q >>> 16) : -((-q) >>> 16);
    endfunction

    function automatic longint clip(longint x, longint lo, longint hi);
        return x < lo ? lo : (x > hi ? hi : x);
    endfunction

    function automatic void regs_reset();
        regs = '{drd_pkg::MODE_SSD, 17'd32768, 17'd16384, 8'sd0, 10'd500, 13'd416, 13'd416};
        pos = '0;
        top_score = '0;
        top_class = '0;
        boxes_in_frame = '0;
        foreach (head[i]) head[i] = '0;
    endfunction

    function automatic void regs_write(logic [2:0] idx, logic [31:0] d);
        case (idx)
            drd_pkg::REG_MODE:      regs.mode = d[2:0];
            drd_pkg::REG_CONF_THR:  regs.conf_thr = d[16:0];
            drd_pkg::REG_BOX_THR:   regs.box_thr = d[16:0];
            drd_pkg::REG_CLASS_OFF: regs.class_off = d[7:0];
            drd_pkg::REG_MAX_BOXES: regs.max_boxes = d[9:0];
            drd_pkg::REG_BLOB_W:    regs.blob_w = d[12:0];
            drd_pkg::REG_BLOB_H:    regs.blob_h = d[12:0];
            default: ;
        endcase
    endfunction

    // Advance the row state by one value; return 1 with the box when the row emits.
    function automatic bit decode_value(logic signed [31:0] v, bit last, bit fs,
                                        output drd_pkg::box_t bx);
        int unsigned idx;
        int unsigned first;
        int unsigned c;
        int          ci, si, ei;
        bit          yolo;
        bit          emit;
        longint      l, t, w, h, cls, conf, bw, bh, x1, y1, x2, y2;
        emit = 0;
        l = 0; t = 0; w = 0; h = 0; cls = 0; conf = 0;
        bx = '0;
        if (fs) begin
            boxes_in_frame = '0;
            pos = '0;
        end
        idx = 32'(pos);
        if (idx < drd_pkg::HEAD_DEPTH) head[idx] = v;
        yolo = regs.mode == drd_pkg::MODE_YOLO_NORM || regs.mode == drd_pkg::MODE_YOLO_PIX;
        first = yolo ? 5 : 4;
        if ((yolo || regs.mode == drd_pkg::MODE_YOLO10) && idx >= first) begin
            c = idx - first;
            if (c < CLASS_LIMIT && (c == 0 || v > top_score)) begin
                top_score = v;
                top_class = c[9:0];
            end
        end
        if (last) begin
            bw = longint'(regs.blob_w);
            bh = longint'(regs.blob_h);
            if (regs.mode == drd_pkg::MODE_RCNN || regs.mode == drd_pkg::MODE_SSD ||
                regs.mode == drd_pkg::MODE_YOLO10_PP) begin
                ci = regs.mode == drd_pkg::MODE_YOLO10_PP ? 5 : 1;
                si = regs.mode == drd_pkg::MODE_YOLO10_PP ? 4 : 2;
                ei = regs.mode == drd_pkg::MODE_YOLO10_PP ? 0 : 3;
                if (longint'(head[si]) > longint'(regs.conf_thr)) begin
                    x1 = head[ei]; y1 = head[ei + 1];
                    x2 = head[ei + 2]; y2 = head[ei + 3];
                    if (regs.mode == drd_pkg::MODE_SSD) begin
                        x1 *= bw; x2 *= bw; y1 *= bh; y2 *= bh;
                    end
                    l = fx_trunc(x1);
                    t = fx_trunc(y1);
                    w = fx_trunc(x2) - l + 1;
                    h = fx_trunc(y2) - t + 1;
                    cls = fx_trunc(longint'(head[ci])) + longint'(regs.class_off);
                    conf = head[si];
                    emit = 1;
                end
            end else if (yolo) begin
                if (idx >= first && longint'(head[4]) >= longint'(regs.box_thr) &&
                    longint'(top_score) >= longint'(regs.conf_thr)) begin
                    x1 = head[0]; y1 = head[1]; x2 = head[2]; y2 = head[3];
                    if (regs.mode == drd_pkg::MODE_YOLO_NORM) begin
                        x1 *= bw; x2 *= bw; y1 *= bh; y2 *= bh;
                    end
                    w = fx_trunc(x2);
                    h = fx_trunc(y2);
                    l = fx_trunc(x1) - w / 2;
                    t = fx_trunc(y1) - h / 2;
                    cls = longint'(top_class);
                    conf = top_score;
                    emit = 1;
                end
            end else if (regs.mode == drd_pkg::MODE_YOLO10) begin
                if (idx >= first && longint'(top_score) >= longint'(regs.conf_thr)) begin
                    x1 = head[0]; y1 = head[1]; x2 = head[2]; y2 = head[3];
                    l = fx_trunc(x1);
                    t = fx_trunc(y1);
                    w = fx_trunc(x2 - x1 + 65536);
                    h = fx_trunc(y2 - y1 + 65536);
                    cls = longint'(top_class);
                    conf = top_score;
                    emit = 1;
                end
            end
            if (emit && boxes_in_frame >= regs.max_boxes) emit = 0;
            if (emit) boxes_in_frame++;
            pos = '0;
            top_score = '0;
            top_class = '0;
        end else if (pos < drd_pkg::IDX_MAX) begin
            pos++;
        end
        bx.left = 16'(clip(l, -32768, 32767));
        bx.top = 16'(clip(t, -32768, 32767));
        bx.width = 16'(clip(w, -32768, 32767));
        bx.height = 16'(clip(h, -32768, 32767));
        bx.class_id = 12'(clip(cls, -2048, 2047));
        bx.confidence = 32'(conf);
        return emit;
    endfunction

    // Offer one item until accepted, at times after a random gap; predict on acceptance.
    task automatic send_item(logic signed [31:0] v, bit last, bit fs,
                             bit typed = 0, drd_pkg::box_t typed_box = '0);
        drd_pkg::box_t bx;
        if ($urandom_range(0, 99) < send_idle_pct) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        push <= 1'b1;
        value <= v;
        row_end <= last;
        frame_start <= fs;
        @(posedge clk);
        while (full) @(posedge clk);
        items_sent++;
        if (decode_value(v, last, fs, bx))
            pending_boxes = {pending_boxes, (typed ? typed_box : bx)};
    endtask

    task automatic drain();
        push <= 1'b0;
        while (pending_boxes.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Registers change only with the block idle.
    task automatic write_reg(logic [2:0] idx, logic [31:0] d);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= d;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        regs_write(idx, d);
        @(posedge clk);
    endtask

    function automatic void add_cfg(logic [2:0] idx, logic [31:0] d);
        drow_t row;
        row = '{1, idx, d, 0, 0, 0, 0, '0};
        script = {script, row};
    endfunction

    function automatic void add_row(logic signed [31:0] vals [$], bit fs,
                                    bit typed = 0, drd_pkg::box_t bx = '0);
        drow_t row;
        foreach (vals[i]) begin
            row = '{0, 0, 0, vals[i], i == vals.size() - 1, fs && i == 0,
                    typed && i == vals.size() - 1, bx};
            script = {script, row};
        end
    endfunction

    // Random value helpers: fractions of the blob, pixel coordinates, scores near a level.
    function automatic logic signed [31:0] frac_val();
        if ($urandom_range(0, 9) == 0) return $urandom();
        return $signed($urandom_range(0, 80000)) - 8000;
    endfunction

    function automatic logic signed [31:0] pix_val();
        if ($urandom_range(0, 9) == 0) return $urandom();
        return $signed($urandom_range(0, 40000000)) - 2000000;
    endfunction

    function automatic logic signed [31:0] score_near(logic [16:0] level);
        if ($urandom_range(0, 19) == 0) return $urandom();
        if ($urandom_range(0, 7) == 0) return $signed({15'd0, level});
        return $signed({15'd0, level}) + $signed($urandom_range(0, 8) * 1024) - 4096;
    endfunction

    function automatic logic [31:0] pick(logic [31:0] a, logic [31:0] b, logic [31:0] r);
        case ($urandom_range(0, 3))
            0: return a;
            1: return b;
            default: return r;
        endcase
    endfunction

    // Send one random row shaped for the current mode; some rows are noise.
    task automatic send_row(bit fs);
        logic signed [31:0] vals [$];
        int n;
        vals = {};
        if ($urandom_range(0, 9) == 0) begin
            n = $urandom_range(1, 10);
            repeat (n) vals = {vals, 32'($urandom())};
        end else begin
            case (regs.mode)
                drd_pkg::MODE_RCNN, drd_pkg::MODE_SSD: begin
                    vals = {vals, 32'($urandom_range(0, 3) << 16)};
                    vals = {vals,
                            32'(($urandom_range(0, 90) << 16) | $urandom_range(0, 65535))};
                    vals = {vals, score_near(regs.conf_thr)};
                    repeat (4)
                        vals = {vals, (regs.mode == drd_pkg::MODE_SSD ? frac_val() : pix_val())};
                end
                drd_pkg::MODE_YOLO_NORM, drd_pkg::MODE_YOLO_PIX: begin
                    repeat (4)
                        vals = {vals,
                                (regs.mode == drd_pkg::MODE_YOLO_NORM ? frac_val() : pix_val())};
                    vals = {vals, score_near(regs.box_thr)};
                    n = $urandom_range(0, 6);
                    repeat (n) vals = {vals, score_near(regs.conf_thr)};
                end
                drd_pkg::MODE_YOLO10: begin
                    repeat (4) vals = {vals, pix_val()};
                    n = $urandom_range(0, 6);
                    repeat (n) vals = {vals, score_near(regs.conf_thr)};
                end
                drd_pkg::MODE_YOLO10_PP: begin
                    repeat (4) vals = {vals, pix_val()};
                    vals = {vals, score_near(regs.conf_thr)};
                    vals = {vals, 32'($signed($urandom_range(0, 200) << 16) - (20 << 16))};
                end
                default: begin
                    n = $urandom_range(1, 9);
                    repeat (n) vals = {vals, 32'($urandom())};
                end
            endcase
        end
        foreach (vals[i])
            send_item(vals[i], i == vals.size() - 1, fs && i == 0);
    endtask

    initial begin
        logic signed [31:0] r [$];
        int rows;
        regs_reset();

        // Directed table: extremes, every mode, strict and at-least thresholds,
        // rows with no class scores, tied scores and the frame limit.
        add_cfg(drd_pkg::REG_MODE, drd_pkg::MODE_RCNN);
        r = {0, 32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h80000000,
             32'h7fffffff, 32'h7fffffff};
        add_row(r, 1, 1, '{-16'sd32768, -16'sd32768, 16'sd32767, 16'sd32767,
                           12'sd2047, 32'sh7fffffff});
        add_cfg(drd_pkg::REG_MODE, drd_pkg::MODE_SSD);
        r = {0, 3 << 16, 65536, 0, 0, 32768, 32768};
        add_row(r, 0, 1, '{16'sd0, 16'sd0, 16'sd209, 16'sd209, 12'sd3, 32'sd65536});
        r = {0, 3 << 16, 32768, 0, 0, 32768, 32768};
        add_row(r, 0);
        add_cfg(drd_pkg::REG_MODE, drd_pkg::MODE_YOLO_NORM);
        r = {32768, 32768, 16384, 16384, 16384, 32768, 32768};
        add_row(r, 0);
        r = {32768, 32768, 16384, 16384, 65536};
        add_row(r, 0);
        add_cfg(drd_pkg::REG_MODE, drd_pkg::MODE_YOLO_PIX);
        r = {100 << 16, 50 << 16, -(7 << 16), 9 << 16, 65536, 0, 65536};
        add_row(r, 0);
        add_cfg(drd_pkg::REG_MODE, drd_pkg::MODE_YOLO10);
        r = {-(5 << 16) - 1, 3 << 16, 40 << 16, 32'h7fffffff, 32768};
        add_row(r, 0);
        add_cfg(drd_pkg::REG_MODE, drd_pkg::MODE_YOLO10_PP);
        add_cfg(drd_pkg::REG_CLASS_OFF, 32'h80);
        r = {0, 0, 10 << 16, 10 << 16, 65536, 32'h80000000};
        add_row(r, 0);
        add_cfg(drd_pkg::REG_MAX_BOXES, 1);
        r = {1 << 16, 2 << 16, 3 << 16, 4 << 16, 65536, 5 << 16};
        add_row(r, 1);
        add_row(r, 0);
        add_row(r, 1);

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (script[i]) begin
            if (script[i].is_cfg) begin
                drain();
                write_reg(script[i].reg_idx, script[i].reg_data);
            end else begin
                send_item(script[i].v, script[i].last, script[i].fs,
                          script[i].typed, script[i].box);
            end
        end

        // Random phases: each walks a mode with fresh register values, extremes included.
        for (int ph = 0; ph < 16; ph++) begin
            drain();
            if (ph == 6) begin
                send_idle_pct = 48;
                recv_idle_pct = 32;
            end else if (ph == 11) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            write_reg(drd_pkg::REG_MODE, ph % 8);
            write_reg(drd_pkg::REG_CONF_THR, pick(0, 131071, $urandom_range(0, 65536)));
            write_reg(drd_pkg::REG_BOX_THR, pick(0, 65536, $urandom_range(0, 65536)));
            write_reg(drd_pkg::REG_CLASS_OFF, pick(32'h80, 32'h7f, $urandom()));
            write_reg(drd_pkg::REG_MAX_BOXES, pick(0, 1023, $urandom_range(1, 40)));
            write_reg(drd_pkg::REG_BLOB_W, pick(1, 8191, $urandom_range(1, 4096)));
            write_reg(drd_pkg::REG_BLOB_H, pick(4096, 1, $urandom_range(1, 4096)));

            // Hold the receiver off for a long stretch while items keep coming;
            // open the thresholds so enough boxes pile up to fill the block.
            if (ph == 3 || ph == 13) begin
                write_reg(drd_pkg::REG_CONF_THR, 0);
                write_reg(drd_pkg::REG_BOX_THR, 0);
                write_reg(drd_pkg::REG_MAX_BOXES, 1023);
                hold_cycles = 400;
            end

            // One very long row runs past the class limit.
            if (ph == 4) begin
                for (int k = 0; k < 1032; k++)
                    send_item(k < 4 ? pix_val() : score_near(regs.conf_thr),
                              k == 1031, k == 0);
            end

            rows = (ph == 3 || ph == 13) ? 24 : $urandom_range(2, 4);
            for (int k = 0; k < rows; k++) begin
                // Pause the sender until every pending box is out.
                if (ph == 8 && k == rows / 2) begin
                    push <= 1'b0;
                    while (pending_boxes.size() != 0) @(posedge clk);
                    @(posedge clk);
                end
                send_row(k == 0 || $urandom_range(0, 19) == 0);
            end
        end

        drain();
        $display("covered %0d items and %0d boxes over 8 mode codes, 16 register sets,",
                 items_sent, boxes_seen);
        $display("frame limits, long rows, receiver hold-off and three idle patterns");
        if (mismatches == 0 && pending_boxes.size() == 0)
            $display("detection_row_decoder_top: match");
        else
            $display("detection_row_decoder_top: mismatch");
        $finish;
    end

    initial begin
        #3ms;
        $display("detection_row_decoder_top: mismatch");
        $finish;
    end

endmodule
